// ===== sv/sts_pkg.sv =====
`default_nettype none

package sts_pkg;

    // Fixed field widths of the stream payloads
    localparam int IDX_W      = 10;
    localparam int VAL_W      = 32;
    localparam int CNT_W      = 11;
    localparam int IN_DATA_W  = 48;  // entry_index + item_value, padded to bytes
    localparam int OUT_DATA_W = 16;  // found + match_index, padded to bytes

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

// ===== sv/sts_ram.sv =====
`default_nettype none

module sts_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/sts_engine.sv =====
`default_nettype none

module sts_engine #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32,
    parameter int AW          = 10,
    parameter int LW          = 11
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic [LW-1:0]                    i_count,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [sts_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  wire logic                             s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic      [sts_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                                  o_wr_en,
    output logic      [AW-1:0]                    o_wr_addr,
    output logic      [VALUE_WIDTH-1:0]           o_wr_data,
    output logic                                  o_rd_en,
    output logic      [AW-1:0]                    o_rd_addr,
    input  wire logic [VALUE_WIDTH-1:0]           i_rd_data
);

    import sts_pkg::*;

    t_state r_state, n_state;
    logic [LW-1:0]          r_low, n_low;
    logic [LW-1:0]          r_hix, n_hix;    // exclusive upper bound
    logic [AW-1:0]          r_mid, n_mid;
    logic [VALUE_WIDTH-1:0] r_key, n_key;
    logic                   r_hit, n_hit;
    logic [AW-1:0]          r_where, n_where;
    logic                   r_out_valid;
    logic                   r_out_found;
    logic [IDX_W-1:0]       r_out_idx;

    logic [IDX_W-1:0]       in_idx;
    logic [VALUE_WIDTH-1:0] in_key;
    logic                   in_acc;
    logic                   slot_free;
    logic                   load_out;
    logic                   probe_eq;
    logic                   probe_lt;
    logic [LW-1:0]          step_low;
    logic [LW-1:0]          step_hix;
    logic [LW-1:0]          src_low;
    logic [LW-1:0]          src_hix;
    logic [LW:0]            mid_sum;

    assign in_idx = s_axis_tdata[IDX_W-1:0];
    assign in_key = VALUE_WIDTH'(s_axis_tdata[IDX_W +: VAL_W]);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !r_out_valid || m_axis_tready;

    // Compare the returned probe against the target, narrow the range
    assign probe_eq = (i_rd_data == r_key);
    assign probe_lt = ($signed(i_rd_data) < $signed(r_key));
    assign step_low = probe_lt ? (LW'(r_mid) + LW'(1)) : r_low;
    assign step_hix = probe_lt ? r_hix : LW'(r_mid);

    // One shared midpoint adder: start range on accept, narrowed range otherwise
    assign src_low = (r_state == ST_IDLE) ? '0 : step_low;
    assign src_hix = (r_state == ST_IDLE) ? i_count : step_hix;
    assign mid_sum = {1'b0, src_low} + {1'b0, src_hix} - (LW+1)'(1);

    assign o_wr_addr = AW'(in_idx);
    assign o_wr_data = in_key;
    assign o_rd_addr = AW'(mid_sum >> 1);

    always_comb begin
        n_state  = r_state;
        n_low    = r_low;
        n_hix    = r_hix;
        n_mid    = r_mid;
        n_key    = r_key;
        n_hit    = r_hit;
        n_where  = r_where;
        o_wr_en  = 1'b0;
        o_rd_en  = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser == OP_WRITE) begin
                        o_wr_en = (32'(in_idx) < TABLE_DEPTH);
                    end else begin
                        n_key = in_key;
                        n_low = '0;
                        n_hix = i_count;
                        if (i_count == '0) begin
                            n_hit   = 1'b0;
                            n_where = '0;
                            n_state = ST_FINISH;
                        end else begin
                            o_rd_en = 1'b1;
                            n_mid   = o_rd_addr;
                            n_state = ST_SEARCH;
                        end
                    end
                end
            end
            ST_SEARCH: begin
                if (probe_eq) begin
                    n_hit   = 1'b1;
                    n_where = r_mid;
                    n_state = ST_FINISH;
                end else begin
                    n_low = step_low;
                    n_hix = step_hix;
                    if (step_low >= step_hix) begin
                        n_hit   = 1'b0;
                        n_where = '0;
                        n_state = ST_FINISH;
                    end else begin
                        o_rd_en = 1'b1;
                        n_mid   = o_rd_addr;
                    end
                end
            end
            ST_FINISH: begin
                if (slot_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_low   <= n_low;
        r_hix   <= n_hix;
        r_mid   <= n_mid;
        r_key   <= n_key;
        r_hit   <= n_hit;
        r_where <= n_where;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_found <= r_hit;
            r_out_idx   <= IDX_W'(r_where);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_W-IDX_W-1)'(0), r_out_idx, r_out_found};

endmodule

`default_nettype wire

// ===== sv/sorted_table_binary_search.sv =====
// Sorted-table binary search. Software loads signed words in ascending order
// with write transfers (tuser = 0: entry_index and item_value in tdata), sets
// the number of loaded entries on the configuration channel, then sends
// search transfers (tuser = 1: item_value is the target). Each search returns
// one result transfer carrying found and match_index (0 when not found); a
// write returns nothing and is ignored if its index lies beyond the table.
// A search issues its first probe when accepted (none for an empty table),
// probes until it hits or the range empties, then retires its result to the
// output register once that is free. The rate is set by the single read port
// of the table memory, one probe per cycle with the compare and the next
// midpoint done in the cycle the read data returns. One search is in flight
// at a time; a finished result sits in an output register so the next
// transfer can be accepted while the result waits. Table contents are undefined after reset.
`default_nettype none

module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration: entry_count
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [sts_pkg::CNT_W-1:0]       i_cfg_data,
    // request stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [sts_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // entry_index, item_value
    input  wire logic                            s_axis_tuser,  // opcode
    // result stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic      [sts_pkg::OUT_DATA_W-1:0]  m_axis_tdata   // found, match_index
);

    import sts_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int LW = $clog2(TABLE_DEPTH + 1);

    logic [CNT_W-1:0]       r_entry_count;
    logic [LW-1:0]          count_clamped;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [VALUE_WIDTH-1:0] rd_data;

    // Configuration writes must land only while idle; the block does not enforce this and always accepts them
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_valid) begin
            r_entry_count <= i_cfg_data;
        end
    end

    // A count beyond the table covers the whole table
    assign count_clamped = (32'(r_entry_count) > TABLE_DEPTH) ? LW'(TABLE_DEPTH)
                                                              : LW'(r_entry_count);

    sts_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW),
        .LW          (LW)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_count       (count_clamped),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data)
    );

    sts_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (VALUE_WIDTH),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

`default_nettype wire

// ===== sv/sts_checker.sv =====
`default_nettype none

module sts_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    input  wire logic                            s_axis_tready,
    input  wire logic                            s_axis_tuser,
    input  wire logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    input  wire logic [sts_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    import sts_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A miss reports index zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[IDX_W:1] == '0)
        else $error("miss with nonzero index");

    // A search holds off further requests while it runs
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_SEARCH |=> !s_axis_tready)
        else $error("request accepted during search");

    // A write does not hold off the request side
    a_write_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_WRITE |=> s_axis_tready)
        else $error("write stalled the request side");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind sorted_table_binary_search sts_checker u_sts_checker (.*);

`default_nettype wire
